// ----- design/assert_macros.svh -----
// Assertion macros shared by the base64 group decoder RTL.
// Depends on nothing; users provide aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define B64_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("b64 assertion failed");
`define B64_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("b64 assertion failed");
`else
`define B64_ASSERT(lbl, prop)
`define B64_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- design/b64_pkg.sv -----
// Types, constants and helper functions of the base64 group decoder.
// Used by every module in the design folder; depends on nothing.
package b64_pkg;

    localparam int MAX_RES      = 3;
    localparam int FIFO_DEPTH   = 8;
    localparam int SEXTET_PLUS  = 62;
    localparam int SEXTET_SLASH = 63;
    localparam int DIGIT_BASE   = 52;
    localparam int LOWER_BASE   = 26;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic        has_byte;
        logic        last_of_run;
        logic        string_done;
        logic [15:0] total_bytes;
    } out_item_t;

    // Results produced by one character: count plus up to three beats.
    typedef struct packed {
        logic [1:0]                    num;
        out_item_t [MAX_RES-1:0]       items;
    } b64_burst_t;

    // Returns {invalid, value}.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'h40;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b0, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b0, 6'(c - 8'h61 + 8'(LOWER_BASE))};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 6'(c - 8'h30 + 8'(DIGIT_BASE))};
        end else if (c == 8'h2B) begin
            r = {1'b0, 6'(SEXTET_PLUS)};
        end else if (c == 8'h2F) begin
            r = {1'b0, 6'(SEXTET_SLASH)};
        end
        return r;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] x);
        return (x == 16'hFFFF) ? x : x + 16'd1;
    endfunction

endpackage

// ----- design/b64_decode_stage.sv -----
// Input register, group state and per-character decode of the base64 decoder.
// Depends on b64_pkg and assert_macros.svh; feeds b64_result_fifo.
`include "assert_macros.svh"
module b64_decode_stage import b64_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    input  logic       space_ok,
    output b64_burst_t burst
);

    logic        in_valid_reg;
    in_item_t    in_data_reg;
    logic [5:0]  sext_reg [MAX_RES];
    logic [5:0]  sext_next [MAX_RES];
    logic [1:0]  pos_reg, pos_next;
    logic [2:0]  inv_reg, inv_next;
    logic        halted_reg, halted_next;
    logic [15:0] cnt_reg, cnt_next;

    logic        take;
    logic        ending;
    logic        active;
    logic        bad;
    logic [5:0]  val;
    logic [6:0]  lut;
    logic [5:0]  s3;
    logic [15:0] t1, t2, t3;
    logic [1:0]  n;
    b64_burst_t  res;

    assign take    = in_valid_reg && space_ok;
    assign s_ready = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_comb begin
        lut    = sextet_of(in_data_reg.char_code);
        bad    = lut[6];
        val    = lut[5:0];
        s3     = bad ? 6'd0 : val;
        ending = (in_data_reg.char_code == 8'd0) || in_data_reg.end_of_string;
        active = !halted_reg && (in_data_reg.char_code != 8'd0);
        t1     = sat_inc(cnt_reg);
        t2     = sat_inc(t1);
        t3     = sat_inc(t2);

        for (int i = 0; i < MAX_RES; i++) begin
            sext_next[i] = sext_reg[i];
        end
        pos_next    = pos_reg;
        inv_next    = inv_reg;
        halted_next = halted_reg;
        cnt_next    = cnt_reg;
        n           = 2'd0;
        res         = '0;

        res.items[0].byte_value  = {sext_reg[0], sext_reg[1][5:4]};
        res.items[1].byte_value  = {sext_reg[1][3:0], sext_reg[2][5:2]};
        res.items[2].byte_value  = {sext_reg[2][1:0], s3};
        res.items[0].total_bytes = t1;
        res.items[1].total_bytes = t2;
        res.items[2].total_bytes = t3;

        if (active) begin
            if (pos_reg != 2'd3) begin
                for (int i = 0; i < MAX_RES; i++) begin
                    if (pos_reg == 2'(i)) begin
                        sext_next[i] = s3;
                        inv_next[i]  = inv_reg[i] | bad;
                    end
                end
                pos_next = pos_reg + 2'd1;
            end else begin
                // Earlier invalid characters cut the group short.
                priority if (inv_reg[0] || inv_reg[1]) begin
                    n           = 2'd0;
                    halted_next = 1'b1;
                end else if (inv_reg[2]) begin
                    n           = 2'd1;
                    halted_next = 1'b1;
                end else if (bad) begin
                    n           = 2'd2;
                    halted_next = 1'b1;
                end else begin
                    n = 2'd3;
                end
                for (int i = 0; i < MAX_RES; i++) begin
                    sext_next[i] = 6'd0;
                end
                pos_next = 2'd0;
                inv_next = 3'd0;
            end
        end

        unique case (n)
            2'd0:    cnt_next = cnt_reg;
            2'd1:    cnt_next = t1;
            2'd2:    cnt_next = t2;
            default: cnt_next = t3;
        endcase
        for (int i = 0; i < MAX_RES; i++) begin
            res.items[i].has_byte = (2'(i) < n);
        end

        if (ending) begin
            if (n == 2'd0) begin
                res.items[0]             = '0;
                res.items[0].total_bytes = cnt_reg;
                n                        = 2'd1;
            end
            res.items[n - 2'd1].string_done = 1'b1;
            for (int i = 0; i < MAX_RES; i++) begin
                sext_next[i] = 6'd0;
            end
            pos_next    = 2'd0;
            inv_next    = 3'd0;
            halted_next = 1'b0;
            cnt_next    = 16'd0;
        end

        if (n != 2'd0) begin
            res.items[n - 2'd1].last_of_run = 1'b1;
        end
        res.num = take ? n : 2'd0;
        burst   = res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_RES; i++) begin
                sext_reg[i] <= 6'd0;
            end
            pos_reg    <= 2'd0;
            inv_reg    <= 3'd0;
            halted_reg <= 1'b0;
            cnt_reg    <= 16'd0;
        end else if (take) begin
            for (int i = 0; i < MAX_RES; i++) begin
                sext_reg[i] <= sext_next[i];
            end
            pos_reg    <= pos_next;
            inv_reg    <= inv_next;
            halted_reg <= halted_next;
            cnt_reg    <= cnt_next;
        end
    end

    `B64_ASSERT(a_end_clears, take && ending |=> pos_reg == 2'd0 && cnt_reg == 16'd0 && !halted_reg)
    `B64_ASSERT(a_halt_silent, take && halted_reg && !ending |-> burst.num == 2'd0)
    `B64_ASSERT(a_end_emits, take && ending |-> burst.num != 2'd0)

endmodule

// ----- design/b64_result_fifo.sv -----
// Result queue of the base64 decoder: takes up to three beats a cycle, gives one.
// Depends on b64_pkg and assert_macros.svh.
`include "assert_macros.svh"
module b64_result_fifo import b64_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  b64_burst_t burst,
    output logic       space_ok,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    out_item_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   widx [MAX_RES];
    logic [PTR_W:0]     sum;
    logic               pop;

    assign space_ok = count_reg <= CNT_W'(DEPTH - MAX_RES);
    assign m_valid  = count_reg != '0;
    assign m_data   = mem_reg[rd_ptr_reg];
    assign pop      = m_valid && m_ready;

    always_comb begin
        for (int i = 0; i < MAX_RES; i++) begin
            sum = {1'b0, wr_ptr_reg} + (PTR_W + 1)'(i);
            if (sum >= (PTR_W + 1)'(DEPTH)) begin
                sum = sum - (PTR_W + 1)'(DEPTH);
            end
            widx[i] = sum[PTR_W-1:0];
        end
        sum = {1'b0, wr_ptr_reg} + (PTR_W + 1)'(burst.num);
        if (sum >= (PTR_W + 1)'(DEPTH)) begin
            sum = sum - (PTR_W + 1)'(DEPTH);
        end
        wr_ptr_next = sum[PTR_W-1:0];
        if (rd_ptr_reg == PTR_W'(DEPTH - 1)) begin
            rd_ptr_next = '0;
        end else begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(burst.num) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
        for (int i = 0; i < MAX_RES; i++) begin
            if (2'(i) < burst.num) begin
                mem_reg[widx[i]] <= burst.items[i];
            end
        end
    end

    `B64_ASSERT(a_no_overflow, count_reg <= CNT_W'(DEPTH))
    `B64_ASSERT(a_push_fits, burst.num != 2'd0 |-> space_ok)
    `B64_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid)

endmodule

// ----- design/base64_group_decoder.sv -----
// Top level of the streaming base64 group decoder.
// Depends on b64_pkg, b64_decode_stage and b64_result_fifo.
//
// Input channel s_*: one character per beat (char_code, end_of_string).
// Result channel m_*: decoded bytes and end-of-string reports, one per beat.
// A character is registered on acceptance and decoded from that register;
// the up to three results it causes enter a small result queue when the
// decoded character leaves the register, and the queue drives m_data.
// One character is taken every cycle while the queue has room for three more
// results; a group of four characters gives at most three bytes, so the
// output port, one beat per cycle while the receiver is ready, keeps up at
// full input rate.
// A zero character or end_of_string always yields at least one result
// carrying string_done and the final byte count.
// When the receiver stalls, the queue fills; a held character waits while
// fewer than three entries are free, and s_ready stays low meanwhile.
// Nothing is lost or repeated.
// Reset (aresetn low at a clock edge) empties the queue, drops any held
// character and clears the group state and byte count.
module base64_group_decoder import b64_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    b64_burst_t burst;
    logic       space_ok;

    b64_decode_stage u_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .space_ok (space_ok),
        .burst    (burst)
    );

    b64_result_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .burst    (burst),
        .space_ok (space_ok),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
